// ----- rtl/core/sqt_pkg.sv -----
package sqt_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned WORD_W    = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

// ----- rtl/core/sqt_if.sv -----
interface sqt_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    sqt_pkg::t_word    value;
    sqt_pkg::t_word    key;
    sqt_pkg::t_word    new_value;

    modport source (output valid, output op, output value, output key, output new_value,
                    input ready);
    modport sink   (input valid, input op, input value, input key, input new_value,
                    output ready);
endinterface

interface sqt_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    sqt_pkg::t_word    data;
    logic              last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ----- rtl/core/searchable_queue_table_unit.sv -----
// Ordered queue of up to DEPTH signed 32-bit words held in a one-read, one-write
// RAM. One item is taken at a time: append answers ok or full, and the walking
// ops answer empty on an empty queue. Search, modify and delete walk every stored
// entry through the single registered read port and one compare; list gives one
// result per entry and waits whenever the output register is not drained. Delete
// moves each later entry down one slot during the same walk. Unknown op codes
// are dropped with no result.
module searchable_queue_table_unit #(
    parameter int unsigned DEPTH = sqt_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sqt_in_if.sink       i_in,
    sqt_out_if.source    o_out
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_RSP  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_hit, n_hit;
    logic [2:0]      r_op, n_op;
    sqt_pkg::t_word  r_key, n_key;
    sqt_pkg::t_word  r_new, n_new;
    logic [1:0]      r_rsp, n_rsp;

    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_ostatus, n_ostatus;
    sqt_pkg::t_word  r_odata, n_odata;
    logic            r_olast, n_olast;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    sqt_pkg::t_word  wr_data;
    sqt_pkg::t_word  rd_data;
    logic            can_emit;
    logic            at_end;
    logic            match;
    logic            accept;

    sqt_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign accept       = i_in.valid && i_in.ready;
    assign can_emit     = !r_ovalid || o_out.ready;
    assign at_end       = ((CW'(r_idx) + CW'(1)) == r_count);
    assign match        = (rd_data == r_key);

    assign o_out.valid  = r_ovalid;
    assign o_out.status = r_ostatus;
    assign o_out.data   = r_odata;
    assign o_out.last   = r_olast;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_op      = r_op;
        n_key     = r_key;
        n_new     = r_new;
        n_rsp     = r_rsp;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        n_olast   = r_olast;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_new;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_in.op;
                    n_key = i_in.key;
                    n_new = i_in.new_value;
                    n_idx = '0;
                    n_hit = 1'b0;
                    case (i_in.op)
                        sqt_pkg::OP_APPEND: begin
                            n_state = S_RSP;
                            if (r_count == CW'(DEPTH)) begin
                                n_rsp = sqt_pkg::ST_FULL;
                            end else begin
                                n_rsp   = sqt_pkg::ST_OK;
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_count);
                                wr_data = i_in.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        sqt_pkg::OP_SEARCH, sqt_pkg::OP_MODIFY,
                        sqt_pkg::OP_DELETE, sqt_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_rsp   = sqt_pkg::ST_EMPTY;
                                n_state = S_RSP;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                case (r_op)
                    sqt_pkg::OP_LIST: begin
                        if (can_emit) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = sqt_pkg::ST_OK;
                            n_odata   = rd_data;
                            n_olast   = at_end;
                            n_state   = at_end ? S_IDLE : S_RD;
                            n_idx     = r_idx + AW'(1);
                        end
                    end
                    sqt_pkg::OP_DELETE: begin
                        // entries after the first match slide down one slot
                        if (r_hit) begin
                            wr_en   = 1'b1;
                            wr_addr = r_idx - AW'(1);
                            wr_data = rd_data;
                        end else if (match) begin
                            n_hit = 1'b1;
                        end
                        if (at_end) begin
                            n_state = S_RSP;
                            if (r_hit || match) begin
                                n_rsp   = sqt_pkg::ST_OK;
                                n_count = r_count - CW'(1);
                            end else begin
                                n_rsp = sqt_pkg::ST_NOT_FOUND;
                            end
                        end else begin
                            n_state = S_RD;
                            n_idx   = r_idx + AW'(1);
                        end
                    end
                    default: begin
                        if (match) begin
                            n_hit = 1'b1;
                            if (r_op == sqt_pkg::OP_MODIFY) begin
                                wr_en = 1'b1;
                            end
                        end
                        if (at_end) begin
                            n_state = S_RSP;
                            n_rsp   = (r_hit || match) ? sqt_pkg::ST_OK
                                                       : sqt_pkg::ST_NOT_FOUND;
                        end else begin
                            n_state = S_RD;
                            n_idx   = r_idx + AW'(1);
                        end
                    end
                endcase
            end
            S_RSP: begin
                if (can_emit) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rsp;
                    n_odata   = '0;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_op      <= n_op;
        r_key     <= n_key;
        r_new     <= n_new;
        r_rsp     <= n_rsp;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
        r_olast   <= n_olast;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.op == sqt_pkg::OP_APPEND && r_count != CW'(DEPTH))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the queue");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (CW'(r_idx) < r_count))
        else $error("walk index past fill count");

    a_status_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != sqt_pkg::ST_OK) |-> (r_odata == '0 && r_olast))
        else $error("status item with data or without last");
`endif

endmodule

// ----- rtl/core/sqt_ram.sv -----
module sqt_ram #(
    parameter int unsigned DEPTH = sqt_pkg::DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  sqt_pkg::t_word       i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output sqt_pkg::t_word       o_rd_data
);

    sqt_pkg::t_word r_mem [DEPTH];
    sqt_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
